### design/lbvs_pkg.sv
// lbvs_pkg: shared types, sizes and saturation helper for the skinning core
// no dependencies
package lbvs_pkg;

  localparam int MAX_BONES     = 64;
  localparam int FRACTION_BITS = 16;
  localparam int INFLUENCES    = 4;
  localparam int WEIGHT_BITS   = 16;
  localparam int MAT_WORDS     = 16;

  localparam int BONE_W    = $clog2(MAX_BONES);
  localparam int MEM_AW    = BONE_W + 4;
  localparam int MEM_DEPTH = MAX_BONES * MAT_WORDS;
  localparam int ACC_W     = 64 - FRACTION_BITS + 2;
  localparam int WPROD_W   = 32 + WEIGHT_BITS + 1;
  localparam int PACC_W    = WPROD_W - WEIGHT_BITS + 2;

  typedef enum logic [1:0] {
    OP_WR_POSE = 2'd0,
    OP_WR_INV  = 2'd1,
    OP_BUILD   = 2'd2,
    OP_SKIN    = 2'd3
  } opcode_e;

  typedef struct packed {
    logic [1:0]         opcode;
    logic [9:0]         matrix_address;
    logic [5:0]         source_bone;
    logic signed [31:0] element_value;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [31:0] nrm_x;
    logic signed [31:0] nrm_y;
    logic signed [31:0] nrm_z;
    logic [23:0]        blend_indices;
    logic [63:0]        blend_weights;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] skinned_x;
    logic signed [31:0] skinned_y;
    logic signed [31:0] skinned_z;
    logic signed [31:0] skinned_nx;
    logic signed [31:0] skinned_ny;
    logic signed [31:0] skinned_nz;
  } out_item_t;

  // decoded command handed from front to back
  typedef struct packed {
    opcode_e                                op;
    logic                                   tgt_ok;
    logic                                   src_ok;
    logic [BONE_W-1:0]                      tgt;
    logic [3:0]                             elem;
    logic [BONE_W-1:0]                      src;
    logic [31:0]                            value;
    logic [2:0][31:0]                       pos;
    logic [2:0][31:0]                       nrm;
    logic [INFLUENCES-1:0][BONE_W-1:0]      bone;
    logic [INFLUENCES-1:0][WEIGHT_BITS-1:0] weight;
  } cmd_t;

  function automatic logic signed [31:0] sat32(input logic signed [ACC_W-1:0] v);
    logic signed [31:0] r;
    if ((&v[ACC_W-1:31]) || !(|v[ACC_W-1:31])) begin
      r = v[31:0];
    end else if (v[ACC_W-1]) begin
      r = {1'b1, 31'b0};
    end else begin
      r = {1'b0, {31{1'b1}}};
    end
    return r;
  endfunction

endpackage

### design/lbvs_front.sv
// lbvs_front: accepts transactions, decodes them into commands, two-entry queue
// depends on lbvs_pkg
module lbvs_front import lbvs_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  in_item_t in_item_i,
  output logic     cmd_valid_o,
  input  logic     cmd_ready_i,
  output cmd_t     cmd_o
);

  cmd_t       fifo_q [2];
  logic       wptr_q, wptr_d, rptr_q, rptr_d;
  logic [1:0] cnt_q, cnt_d;
  cmd_t       dec;
  logic       push, pop;

  always_comb begin
    dec        = '0;
    dec.op     = opcode_e'(in_item_i.opcode);
    dec.tgt_ok = 32'(in_item_i.matrix_address[9:4]) < MAX_BONES;
    dec.src_ok = 32'(in_item_i.source_bone) < MAX_BONES;
    dec.tgt    = BONE_W'(in_item_i.matrix_address[9:4]);
    dec.elem   = in_item_i.matrix_address[3:0];
    dec.src    = BONE_W'(in_item_i.source_bone);
    dec.value  = in_item_i.element_value;
    dec.pos    = {in_item_i.pos_z, in_item_i.pos_y, in_item_i.pos_x};
    dec.nrm    = {in_item_i.nrm_z, in_item_i.nrm_y, in_item_i.nrm_x};
    for (int i = 0; i < INFLUENCES; i++) begin
      dec.bone[i] = BONE_W'(in_item_i.blend_indices[6*i +: 6]);
      // an influence on a missing bone contributes nothing
      if (32'(in_item_i.blend_indices[6*i +: 6]) < MAX_BONES) begin
        dec.weight[i] = in_item_i.blend_weights[WEIGHT_BITS*i +: WEIGHT_BITS];
      end else begin
        dec.weight[i] = '0;
      end
    end
  end

  assign in_ready_o  = cnt_q != 2'd2;
  assign cmd_valid_o = cnt_q != 2'd0;
  assign cmd_o       = fifo_q[rptr_q];
  assign push        = in_valid_i && in_ready_o;
  assign pop         = cmd_valid_o && cmd_ready_i;

  always_comb begin
    wptr_d = push ? ~wptr_q : wptr_q;
    rptr_d = pop ? ~rptr_q : rptr_q;
    cnt_d  = cnt_q + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wptr_q] <= dec;
    end
  end

endmodule

### design/lbvs_back.sv
// lbvs_back: matrix stores, build and skin sequencer, output register
// depends on lbvs_pkg
module lbvs_back import lbvs_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      cmd_valid_i,
  output logic      cmd_ready_o,
  input  cmd_t      cmd_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_item_o
);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_RUN   = 4'b0010,
    ST_DRAIN = 4'b0100,
    ST_EMIT  = 4'b1000
  } state_e;

  typedef struct packed {
    logic [1:0] hi;   // column (build) or influence (skin)
    logic [1:0] row;
    logic [1:0] k;
    logic       last;
  } tag_t;

  state_e state_q, state_d;
  cmd_t   cmd_q;
  logic [5:0] cnt_q, cnt_d;
  logic   is_build;
  logic   issue, issue_last;

  logic [31:0] pose_mem [MEM_DEPTH];
  logic [31:0] inv_mem  [MEM_DEPTH];
  logic [31:0] skin_mem [MEM_DEPTH];
  logic [31:0] pose_rd_q, inv_rd_q, skin_rd_q;
  logic [MEM_AW-1:0] pose_ra, inv_ra, skin_ra;

  logic v1_q, v2_q, v3_q, v4_q;
  tag_t t1_q, t2_q, t3_q, t4_q;
  logic signed [63:0] prod_a_q, prod_n_q;
  logic [31:0] m2_q;
  logic signed [ACC_W-1:0] acc_a_q, acc_n_q, sum_a, sum_n;
  logic signed [ACC_W-1:0] row_p_q, row_n_q;
  logic signed [WPROD_W-1:0] wp_q, wn_q;
  logic signed [PACC_W-1:0] pacc_q [3];
  logic signed [PACC_W-1:0] nacc_q [3];
  logic [31:0] vec_p, vec_n, op_a, op_b;

  logic      out_valid_q;
  out_item_t out_q;

  assign is_build    = cmd_q.op == OP_BUILD;
  assign cmd_ready_o = state_q == ST_IDLE;
  assign issue       = state_q == ST_RUN;
  assign issue_last  = is_build ? (cnt_q == 6'd63) : (cnt_q == 6'b111011);

  // sequencer
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    case (state_q)
      ST_IDLE: begin
        cnt_d = '0;
        if (cmd_valid_i) begin
          case (cmd_i.op)
            OP_BUILD: if (cmd_i.tgt_ok && cmd_i.src_ok) state_d = ST_RUN;
            OP_SKIN:  state_d = ST_RUN;
            default:  state_d = ST_IDLE;
          endcase
        end
      end
      ST_RUN: begin
        if (!is_build && cnt_q[3:0] == 4'b1011) begin
          cnt_d = {cnt_q[5:4] + 2'd1, 4'b0000};
        end else begin
          cnt_d = cnt_q + 6'd1;
        end
        if (issue_last) state_d = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (is_build && v2_q && t2_q.last) state_d = ST_IDLE;
        if (!is_build && v4_q && t4_q.last) state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (!out_valid_q || out_ready_i) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
      v1_q    <= 1'b0;
      v2_q    <= 1'b0;
      v3_q    <= 1'b0;
      v4_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      v1_q    <= issue;
      v2_q    <= v1_q;
      v3_q    <= v2_q && !is_build && t2_q.k == 2'd3;
      v4_q    <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && cmd_valid_i) begin
      cmd_q <= cmd_i;
    end
  end

  // store addresses: word = bone * 16 + col * 4 + row
  assign pose_ra = {cmd_q.src, cnt_q[1:0], cnt_q[3:2]};
  assign inv_ra  = {cmd_q.tgt, cnt_q[5:4], cnt_q[1:0]};
  assign skin_ra = {cmd_q.bone[cnt_q[5:4]], cnt_q[1:0], cnt_q[3:2]};

  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && cmd_valid_i && cmd_i.tgt_ok) begin
      if (cmd_i.op == OP_WR_POSE) pose_mem[{cmd_i.tgt, cmd_i.elem}] <= cmd_i.value;
      if (cmd_i.op == OP_WR_INV)  inv_mem[{cmd_i.tgt, cmd_i.elem}]  <= cmd_i.value;
    end
    pose_rd_q <= pose_mem[pose_ra];
    inv_rd_q  <= inv_mem[inv_ra];
  end

  always_ff @(posedge clk_i) begin
    if (v2_q && is_build && t2_q.k == 2'd3) begin
      skin_mem[{cmd_q.tgt, t2_q.hi, t2_q.row}] <= sat32(sum_a);
    end
    skin_rd_q <= skin_mem[skin_ra];
  end

  // stage 1 operand select
  always_comb begin
    case (t1_q.k)
      2'd0:    begin vec_p = cmd_q.pos[0]; vec_n = cmd_q.nrm[0]; end
      2'd1:    begin vec_p = cmd_q.pos[1]; vec_n = cmd_q.nrm[1]; end
      2'd2:    begin vec_p = cmd_q.pos[2]; vec_n = cmd_q.nrm[2]; end
      default: begin vec_p = '0;           vec_n = '0;           end
    endcase
    op_a = is_build ? pose_rd_q : skin_rd_q;
    op_b = is_build ? inv_rd_q : vec_p;
  end

  // stage 3 running sums
  always_comb begin
    sum_a = ACC_W'($signed(prod_a_q[63:FRACTION_BITS]));
    sum_n = ACC_W'($signed(prod_n_q[63:FRACTION_BITS]));
    if (t2_q.k != 2'd0) begin
      sum_a = sum_a + acc_a_q;
      sum_n = sum_n + acc_n_q;
    end
  end

  always_ff @(posedge clk_i) begin
    t1_q <= '{hi: cnt_q[5:4], row: cnt_q[3:2], k: cnt_q[1:0], last: issue_last};
    t2_q <= t1_q;
    t3_q <= t2_q;
    t4_q <= t3_q;
    prod_a_q <= $signed(op_a) * $signed(op_b);
    prod_n_q <= $signed(skin_rd_q) * $signed(vec_n);
    m2_q     <= skin_rd_q;
    if (v2_q) begin
      acc_a_q <= sum_a;
      acc_n_q <= sum_n;
      row_p_q <= acc_a_q + ACC_W'($signed(m2_q));
      row_n_q <= acc_n_q;
    end
    wp_q <= sat32(row_p_q) * $signed({1'b0, cmd_q.weight[t3_q.hi]});
    wn_q <= sat32(row_n_q) * $signed({1'b0, cmd_q.weight[t3_q.hi]});
    if (state_q == ST_IDLE) begin
      for (int r = 0; r < 3; r++) begin
        pacc_q[r] <= '0;
        nacc_q[r] <= '0;
      end
    end else if (v4_q) begin
      pacc_q[t4_q.row] <= pacc_q[t4_q.row]
                          + PACC_W'($signed(wp_q[WPROD_W-1:WEIGHT_BITS]));
      nacc_q[t4_q.row] <= nacc_q[t4_q.row]
                          + PACC_W'($signed(wn_q[WPROD_W-1:WEIGHT_BITS]));
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (state_q == ST_EMIT && (!out_valid_q || out_ready_i)) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_EMIT && (!out_valid_q || out_ready_i)) begin
      out_q.skinned_x  <= sat32(ACC_W'(pacc_q[0]));
      out_q.skinned_y  <= sat32(ACC_W'(pacc_q[1]));
      out_q.skinned_z  <= sat32(ACC_W'(pacc_q[2]));
      out_q.skinned_nx <= sat32(ACC_W'(nacc_q[0]));
      out_q.skinned_ny <= sat32(ACC_W'(nacc_q[1]));
      out_q.skinned_nz <= sat32(ACC_W'(nacc_q[2]));
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

### design/linear_blend_vertex_skinning_core.sv
// linear_blend_vertex_skinning_core: top level of the four-influence skinning core
// depends on lbvs_pkg, lbvs_front, lbvs_back
//
// Four-influence linear blend skinning in signed Q16.16. Matrix word writes
// (pose, inverse bind) go straight into the stores of the back end. A skin
// matrix build streams 64 products through one multiplier. A vertex reads 12
// words of each of its four skin matrices from the single read port of the
// skin store, one word a cycle; that memory port sets the vertex rate.
// Position and normal are transformed in parallel by two multipliers. A
// two-entry command queue sits between the input decoder and the back end,
// and the result sits in an output register, so a new transaction can start
// while a finished result still waits to be taken. Stores are not cleared at
// reset.
module linear_blend_vertex_skinning_core import lbvs_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_item_o
);

  // decoded command between front and back
  logic cmd_valid, cmd_ready;
  cmd_t cmd;

  lbvs_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item_i),
    .cmd_valid_o (cmd_valid),
    .cmd_ready_i (cmd_ready),
    .cmd_o       (cmd)
  );

  lbvs_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_ready_o (cmd_ready),
    .cmd_i       (cmd),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

endmodule
